// File: rtl/assert_macros.svh
// Assertion helper macros used by the bucketed hash table RTL.
// No dependencies; include by bare file name in the files that check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define BHT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/bht_pkg.sv
// Shared types and constants for the bucketed hash table.
// No dependencies; imported by every module of the block except bht_ram.
package bht_pkg;

   localparam int DEF_NUM_BUCKETS  = 16;
   localparam int DEF_BUCKET_SLOTS = 4;

   localparam int CMD_W     = 2;
   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;

   localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_SEARCH = 2'd1;
   localparam cmd_type CMD_DELETE = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic              found;
      logic [VAL_W-1:0]  result_value;
      logic              insert_dropped;
   } rsp_type;

   typedef struct packed {
      logic    write;
      rsp_type rsp;
   } upd_type;

endpackage

// File: rtl/bht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bht_bucket_index.sv
// Bucket index unit: non-negative remainder of a signed key by the bucket count.
// Depends on bht_pkg. Power-of-two counts register the low key bits; others register
// a reciprocal multiply, then the remainder and sign correction.
module bht_bucket_index
   import bht_pkg::*;
#(
   parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_W-1:0]               key,
   output logic                           done,
   output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);

   localparam int BKT_W = $clog2(NUM_BUCKETS);

   logic             done_ff;
   logic [BKT_W-1:0] bucket_ff;

   generate
      if ((1 << BKT_W) == NUM_BUCKETS) begin : g_pow2
         // two's complement low bits are already the non-negative remainder
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               bucket_ff <= key[BKT_W-1:0];
            end
         end
      end else begin : g_recip
         localparam int REM_W  = BKT_W + 1;
         localparam int SHIFT  = KEY_W + BKT_W;
         localparam int PROD_W = 2 * KEY_W + 1;
         // ceil(2^SHIFT / NUM_BUCKETS) gives the exact quotient of any 32-bit key
         localparam logic [63:0] RECIP_FULL =
            ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
         localparam logic [KEY_W:0] RECIP = RECIP_FULL[KEY_W:0];
         // remainder of 2^KEY_W, taken off again for negative keys
         localparam int OFFSET = int'((64'd1 << KEY_W) % 64'(NUM_BUCKETS));

         logic              stage_ff;
         logic              neg_ff;
         logic [REM_W-1:0]  low_ff;
         logic [PROD_W-1:0] prod_ff;
         logic [KEY_W-1:0]  quot;
         logic [KEY_W-1:0]  quot_n;
         logic [REM_W-1:0]  rem_raw;
         logic [REM_W-1:0]  rem_fix;

         always_comb begin
            quot    = KEY_W'(prod_ff[PROD_W-1:SHIFT]);
            quot_n  = quot * KEY_W'(NUM_BUCKETS);
            // true remainder is below the bucket count, so low bits suffice
            rem_raw = low_ff - quot_n[REM_W-1:0];
            if (!neg_ff) begin
               rem_fix = rem_raw;
            end else if (rem_raw >= REM_W'(OFFSET)) begin
               rem_fix = rem_raw - REM_W'(OFFSET);
            end else begin
               rem_fix = rem_raw + REM_W'(NUM_BUCKETS) - REM_W'(OFFSET);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= 1'b0;
               done_ff  <= 1'b0;
            end else begin
               stage_ff <= start;
               done_ff  <= stage_ff;
            end
            if (start) begin
               prod_ff <= PROD_W'(key) * PROD_W'(RECIP);
               neg_ff  <= key[KEY_W-1];
               low_ff  <= key[REM_W-1:0];
            end
            if (stage_ff) begin
               bucket_ff <= rem_fix[BKT_W-1:0];
            end
         end
      end
   endgenerate

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

// File: rtl/bht_row_update.sv
// Bucket row engine: parallel key compare, insert append, delete with compaction.
// Depends on bht_pkg. Row layout: fill count on top, then values, keys at bit 0.
module bht_row_update
   import bht_pkg::*;
#(
   parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS
) (
   input  cmd_type    cmd,
   input  logic [KEY_W-1:0] key,
   input  logic [VAL_W-1:0] value,
   input  logic [$clog2(BUCKET_SLOTS+1)+BUCKET_SLOTS*(KEY_W+VAL_W)-1:0] row_rd,
   output logic [$clog2(BUCKET_SLOTS+1)+BUCKET_SLOTS*(KEY_W+VAL_W)-1:0] row_wr,
   output upd_type    upd
);

   localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
   localparam int ROW_W  = FILL_W + BUCKET_SLOTS * (KEY_W + VAL_W);

   logic [FILL_W-1:0]       fill_raw;
   logic [FILL_W-1:0]       fill;
   logic [FILL_W-1:0]       new_fill;
   logic [KEY_W-1:0]        keys     [BUCKET_SLOTS];
   logic [VAL_W-1:0]        vals     [BUCKET_SLOTS];
   logic [KEY_W-1:0]        new_keys [BUCKET_SLOTS];
   logic [VAL_W-1:0]        new_vals [BUCKET_SLOTS];
   logic [BUCKET_SLOTS-1:0] match;
   logic [BUCKET_SLOTS-1:0] shift;
   logic                    hit;
   logic [VAL_W-1:0]        hit_val;

   always_comb begin
      fill_raw = row_rd[ROW_W-1 -: FILL_W];
      fill     = (fill_raw > FILL_W'(BUCKET_SLOTS)) ? FILL_W'(BUCKET_SLOTS) : fill_raw;
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
         keys[i]  = row_rd[i*KEY_W +: KEY_W];
         vals[i]  = row_rd[BUCKET_SLOTS*KEY_W + i*VAL_W +: VAL_W];
         match[i] = (keys[i] == key) && (FILL_W'(i) < fill);
      end
   end

   // lowest matching slot wins; shift marks it and every slot above it
   always_comb begin
      logic seen;
      seen    = 1'b0;
      hit     = 1'b0;
      hit_val = MISS_VALUE;
      for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit     = 1'b1;
            hit_val = vals[i];
         end
      end
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
         seen     = seen | match[i];
         shift[i] = seen;
      end
   end

   always_comb begin
      new_keys = keys;
      new_vals = vals;
      new_fill = fill;
      upd.write              = 1'b0;
      upd.rsp.found          = 1'b0;
      upd.rsp.result_value   = MISS_VALUE;
      upd.rsp.insert_dropped = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            if (fill == FILL_W'(BUCKET_SLOTS)) begin
               upd.rsp.insert_dropped = 1'b1;
            end else begin
               for (int i = 0; i < BUCKET_SLOTS; i++) begin
                  if (FILL_W'(i) == fill) begin
                     new_keys[i] = key;
                     new_vals[i] = value;
                  end
               end
               new_fill  = fill + 1'b1;
               upd.write = 1'b1;
            end
         end
         CMD_SEARCH: begin
            upd.rsp.found        = hit;
            upd.rsp.result_value = hit_val;
         end
         CMD_DELETE: begin
            if (hit) begin
               upd.rsp.found = 1'b1;
               upd.write     = 1'b1;
               new_fill      = fill - 1'b1;
               for (int i = 0; i < BUCKET_SLOTS - 1; i++) begin
                  if (shift[i]) begin
                     new_keys[i] = keys[i+1];
                     new_vals[i] = vals[i+1];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      row_wr[ROW_W-1 -: FILL_W] = new_fill;
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
         row_wr[i*KEY_W +: KEY_W]                      = new_keys[i];
         row_wr[BUCKET_SLOTS*KEY_W + i*VAL_W +: VAL_W] = new_vals[i];
      end
   end

endmodule

// File: rtl/bucketed_hash_table_unit.sv
// Bucketed key/value table: one bucket row per RAM word, read-modify-write per request.
// Depends on bht_pkg, bht_ram, bht_bucket_index, bht_row_update and assert_macros.svh.
//
// Usage:
//   req_* channel carries one command (insert, search, delete), a signed key and a
//   value; rsp_* channel returns found, result_value and insert_dropped, one result
//   per request, in request order. Both channels use valid/ready.
//   Each bucket is one RAM word holding its fill count and all slots, so a request
//   is a single row read, a parallel compare of all slots and one row write.
//   From the request transfer, rsp_valid rises through the bucket index unit, the
//   row read and the result register; when NUM_BUCKETS is not a power of two the
//   index unit (remainder by the bucket count through a registered reciprocal
//   multiply) first registers the product. One request is in flight at a time.
//   The result sits in an output register: the next request is taken while
//   it waits, and only the row write-back holds if rsp_ready stays low.
//   Reset starts a clearing pass that zeroes every row in turn;
//   req_ready stays low until it finishes and the table is empty.
module bucketed_hash_table_unit
   import bht_pkg::*;
#(
   parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
   parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic signed [VAL_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic              rsp_insert_dropped
);

`include "assert_macros.svh"

   localparam int BKT_W  = $clog2(NUM_BUCKETS);
   localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
   localparam int ROW_W  = FILL_W + BUCKET_SLOTS * (KEY_W + VAL_W);

   state_type        state_ff, state_in;
   cmd_type          cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [BKT_W-1:0] clr_cnt_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;

   logic             idx_start;
   logic             idx_done;
   logic [BKT_W-1:0] idx_bucket;
   logic             out_free;
   logic             ram_wr_en;
   logic [BKT_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_wr;
   upd_type          upd;

   bht_bucket_index #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_index (
      .clock (clock),
      .reset (reset),
      .start (idx_start),
      .key   (req_key),
      .done  (idx_done),
      .bucket(idx_bucket)
   );

   bht_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NUM_BUCKETS)
   ) u_rows (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(idx_bucket),
      .rd_data(row_rd)
   );

   bht_row_update #(
      .BUCKET_SLOTS(BUCKET_SLOTS)
   ) u_update (
      .cmd   (cmd_ff),
      .key   (key_ff),
      .value (value_ff),
      .row_rd(row_rd),
      .row_wr(row_wr),
      .upd   (upd)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (idx_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      idx_start   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_bucket;
      ram_wr_data = row_wr;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            idx_start = req_valid;
         end
         ST_HASH: begin
            ram_rd_en = idx_done;
         end
         ST_EXEC: begin
            // write back only when the result can be presented
            ram_wr_en = upd.write && out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EXEC && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
      if (req_valid && req_ready) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (state_ff == ST_EXEC && out_free) begin
         rsp_ff <= upd.rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_ff.found;
   assign rsp_result_value   = rsp_ff.result_value;
   assign rsp_insert_dropped = rsp_ff.insert_dropped;

   `BHT_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC, "result appeared without a row update")
   `BHT_ASSERT(a_done_in_hash, clock, reset, idx_done |-> state_ff == ST_HASH, "bucket index finished outside the hash wait")
   `BHT_NEVER(a_found_and_dropped, clock, reset, rsp_valid_ff && rsp_found && rsp_insert_dropped, "result both found and dropped")
   `BHT_ASSERT(a_miss_value, clock, reset, (rsp_valid_ff && !rsp_found) |-> rsp_ff.result_value == MISS_VALUE, "miss did not return all ones")

endmodule
